// ===== hdl/bjas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjas_pkg: shared types and constants of the job admission scheduler
// Command, event and reply codes, datapath operations and the command and
// status records exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package bjas_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned CNT_W           = 5;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [CNT_W-1:0] MAX_RUN_RST = 5'd4;
  localparam logic [CNT_W-1:0] QCAP_RST    = 5'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNNING    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 1'b1;

  // finish outcome codes
  localparam logic [1:0] OUTCOME_SUCCEEDED = 2'd0;
  localparam logic [1:0] OUTCOME_CANCELLED = 2'd2;

  typedef enum logic [1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_CANCEL   = 2'd1,
    FUNC_FINISH   = 2'd2,
    FUNC_SHUTDOWN = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    EV_QUEUED    = 3'd0,
    EV_RUNNING   = 3'd1,
    EV_SUCCEEDED = 3'd2,
    EV_FAILED    = 3'd3,
    EV_CANCELLED = 3'd4
  } ev_state_e;

  typedef enum logic [2:0] {
    RC_ACCEPTED   = 3'd0,
    RC_INVALID_ID = 3'd1,
    RC_SHUTTING   = 3'd2,
    RC_DUPLICATE  = 3'd3,
    RC_QUEUE_FULL = 3'd4,
    RC_FOUND      = 3'd5,
    RC_NOT_FOUND  = 3'd6,
    RC_DONE       = 3'd7
  } reply_e;

  typedef enum logic [4:0] {
    OP_NONE        = 5'd0,
    OP_LOAD        = 5'd1,
    OP_SHUT        = 5'd2,
    OP_T_RD        = 5'd3,
    OP_T_CMP       = 5'd4,
    OP_START       = 5'd5,
    OP_ENQ         = 5'd6,
    OP_CLR_HIT     = 5'd7,
    OP_Q_RD        = 5'd8,
    OP_Q_CMP       = 5'd9,
    OP_S_RD        = 5'd10,
    OP_S_WR        = 5'd11,
    OP_Q_DEC       = 5'd12,
    OP_FIN         = 5'd13,
    OP_POP_RD      = 5'd14,
    OP_POP_RUN     = 5'd15,
    OP_POP_CLR     = 5'd16,
    OP_EMIT_EV_IN  = 5'd17,
    OP_EMIT_EV_POP = 5'd18,
    OP_EMIT_REPLY  = 5'd19
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    ev_state_e ev_state;
    reply_e    reply;
  } cmd_t;

  typedef struct packed {
    logic      out_free;
    func_e     func;
    logic      key_zero;
    logic      accepting;
    logic      match_now;
    logic      tidx_last;
    logic      hit;
    logic      hit_run;
    logic      free_ok;
    logic      run_lt_max;
    logic      q_full;
    logic      q_nonempty;
    logic      qmatch_now;
    logic      more1;
    logic      more2;
    logic      promo_ok;
    ev_state_e fin_state;
  } sts_t;

endpackage

// ===== hdl/bjas_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjas_dp: scheduler datapath
// Key table memory with valid and running flags, waiting queue memory,
// counters, configuration registers and the result output register.
// ----------------------------------------------------------------------------
module bjas_dp #(
  parameter int unsigned QUEUE_DEPTH = bjas_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = bjas_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [bjas_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bjas_pkg::CNT_W-1:0]         cfg_data_i,
  output logic                               cfg_ready_o,
  input  logic [1:0]                         func_i,
  input  logic [bjas_pkg::ID_W-1:0]          session_id_i,
  input  logic [bjas_pkg::ID_W-1:0]          job_id_i,
  input  logic [1:0]                         job_outcome_i,
  input  bjas_pkg::cmd_t                     cmd_i,
  output bjas_pkg::sts_t                     sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               item_kind_o,
  output logic [bjas_pkg::ID_W-1:0]          event_session_o,
  output logic [bjas_pkg::ID_W-1:0]          event_job_o,
  output logic [2:0]                         event_state_o,
  output logic [2:0]                         reply_code_o,
  output logic [bjas_pkg::CNT_W-1:0]         queued_now_o,
  output logic [bjas_pkg::CNT_W-1:0]         running_now_o,
  output logic [bjas_pkg::CNT_W-1:0]         queued_peak_o,
  output logic [bjas_pkg::CNT_W-1:0]         running_peak_o,
  output logic                               accepting_flag_o,
  output logic                               last_item_o
);

  localparam int unsigned QIW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned TIW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned KEY_W  = 2 * bjas_pkg::ID_W;
  localparam int unsigned FE_W   = KEY_W + TIW;
  localparam int unsigned CNT_W  = bjas_pkg::CNT_W;
  localparam int unsigned CW     = ((QIW > CNT_W) ? QIW : CNT_W) + 2;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned QD_CAP = (QUEUE_DEPTH > CNT_MAX) ? CNT_MAX : QUEUE_DEPTH;
  localparam logic [QIW:0]       QD_EXT  = (QIW+1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]   QD_C    = CNT_W'(QD_CAP);
  localparam logic [TIW-1:0]     T_LAST  = TIW'(TABLE_DEPTH - 1);

  // wrap a queue position sum back into the ring
  function automatic logic [QIW-1:0] qwrap(input logic [QIW:0] sum);
    logic [QIW:0] adj;
    adj = (sum >= QD_EXT) ? (sum - QD_EXT) : sum;
    return adj[QIW-1:0];
  endfunction

  // configuration
  logic [CNT_W-1:0] max_run_q, qcap_q, cap;

  // captured command
  bjas_pkg::func_e          func_q;
  logic [bjas_pkg::ID_W-1:0] sid_q, jid_q;
  logic [1:0]               outcome_q;
  logic [KEY_W-1:0]         key;

  // key table
  logic [KEY_W-1:0] tkey_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] tkey_rd_q;
  logic [TABLE_DEPTH-1:0] valid_q, run_q;
  logic [TIW-1:0]   tidx_q, hit_idx_q, free_idx_q;
  logic             hit_q, free_ok_q;
  logic             t_match, tbl_we;

  // waiting queue
  logic [FE_W-1:0]  fifo_mem [QUEUE_DEPTH];
  logic [FE_W-1:0]  fifo_rd_q;
  logic [QIW-1:0]   head_q, qpos_q;
  logic [QIW-1:0]   fifo_raddr, fifo_waddr;
  logic [FE_W-1:0]  fifo_wdata;
  logic             fifo_re, fifo_we;
  logic [QIW:0]     head_w, qpos_w1, cnt_q1;
  logic [TIW-1:0]   pop_slot;
  logic             q_match;
  logic [CW-1:0]    qpos_c, cnt_c;
  logic             more1, more2;

  // counters
  logic [CNT_W-1:0] count_q, running_q, qpeak_q, rpeak_q;
  logic [CNT_W-1:0] count_inc, running_inc;
  logic             accepting_q;

  // output register
  logic             out_valid_q, out_free, emit;
  bjas_pkg::ev_state_e fin_state;

  assign key         = {sid_q, jid_q};
  assign cap         = (qcap_q < QD_C) ? qcap_q : QD_C;
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= bjas_pkg::MAX_RUN_RST;
      qcap_q    <= bjas_pkg::QCAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bjas_pkg::CFG_MAX_RUNNING:    max_run_q <= cfg_data_i;
        bjas_pkg::CFG_QUEUE_CAPACITY: qcap_q    <= cfg_data_i;
        default:                      max_run_q <= max_run_q;
      endcase
    end
  end

  // capture the command item
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == bjas_pkg::OP_LOAD) begin
      func_q    <= bjas_pkg::func_e'(func_i);
      sid_q     <= session_id_i;
      jid_q     <= job_id_i;
      outcome_q <= job_outcome_i;
    end
  end

  // key table memory: one write, one registered read
  assign tbl_we = (cmd_i.op == bjas_pkg::OP_START) || (cmd_i.op == bjas_pkg::OP_ENQ);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tkey_mem[free_idx_q] <= key;
    end
    if (cmd_i.op == bjas_pkg::OP_T_RD) begin
      tkey_rd_q <= tkey_mem[tidx_q];
    end
  end

  assign t_match = valid_q[tidx_q] && (tkey_rd_q == key);

  // queue addressing
  assign head_w  = {1'b0, head_q};
  assign qpos_w1 = {1'b0, qpos_q};
  assign cnt_q1  = (QIW+1)'(count_q);
  assign pop_slot = fifo_rd_q[TIW-1:0];
  assign q_match  = (fifo_rd_q[FE_W-1:TIW] == key);
  assign qpos_c   = CW'(qpos_q);
  assign cnt_c    = CW'(count_q);
  assign more1    = (qpos_c + CW'(1)) < cnt_c;
  assign more2    = (qpos_c + CW'(2)) < cnt_c;

  always_comb begin
    fifo_re    = 1'b0;
    fifo_raddr = head_q;
    fifo_we    = 1'b0;
    fifo_waddr = qwrap(head_w + qpos_w1);
    fifo_wdata = fifo_rd_q;
    unique case (cmd_i.op)
      bjas_pkg::OP_Q_RD: begin
        fifo_re    = 1'b1;
        fifo_raddr = qwrap(head_w + qpos_w1);
      end
      bjas_pkg::OP_S_RD: begin
        fifo_re    = 1'b1;
        fifo_raddr = qwrap(head_w + qpos_w1 + (QIW+1)'(1));
      end
      bjas_pkg::OP_POP_RD: begin
        fifo_re    = 1'b1;
      end
      bjas_pkg::OP_S_WR: begin
        fifo_we    = 1'b1;
      end
      bjas_pkg::OP_ENQ: begin
        fifo_we    = 1'b1;
        fifo_waddr = qwrap(head_w + cnt_q1);
        fifo_wdata = {key, free_idx_q};
      end
      default: begin
        fifo_re    = 1'b0;
      end
    endcase
  end

  // queue memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
    if (fifo_re) begin
      fifo_rd_q <= fifo_mem[fifo_raddr];
    end
  end

  assign count_inc   = count_q + CNT_W'(1);
  assign running_inc = running_q + CNT_W'(1);

  // flags, counters and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      run_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      running_q   <= '0;
      qpeak_q     <= '0;
      rpeak_q     <= '0;
      accepting_q <= 1'b1;
      tidx_q      <= '0;
      qpos_q      <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      free_ok_q   <= 1'b0;
      free_idx_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        bjas_pkg::OP_LOAD: begin
          tidx_q    <= '0;
          qpos_q    <= '0;
          hit_q     <= 1'b0;
          free_ok_q <= 1'b0;
        end
        bjas_pkg::OP_SHUT: begin
          accepting_q <= 1'b0;
        end
        bjas_pkg::OP_T_CMP: begin
          if (t_match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= tidx_q;
          end
          if (!valid_q[tidx_q] && !free_ok_q) begin
            free_ok_q  <= 1'b1;
            free_idx_q <= tidx_q;
          end
          if (tidx_q != T_LAST) begin
            tidx_q <= tidx_q + TIW'(1);
          end
        end
        bjas_pkg::OP_START: begin
          valid_q[free_idx_q] <= 1'b1;
          run_q[free_idx_q]   <= 1'b1;
          running_q           <= running_inc;
          if (running_inc > rpeak_q) rpeak_q <= running_inc;
        end
        bjas_pkg::OP_ENQ: begin
          valid_q[free_idx_q] <= 1'b1;
          run_q[free_idx_q]   <= 1'b0;
          count_q             <= count_inc;
          if (count_inc > qpeak_q) qpeak_q <= count_inc;
        end
        bjas_pkg::OP_CLR_HIT: begin
          valid_q[hit_idx_q] <= 1'b0;
          run_q[hit_idx_q]   <= 1'b0;
        end
        bjas_pkg::OP_Q_CMP: begin
          if (!q_match && more1) qpos_q <= qpos_q + QIW'(1);
        end
        bjas_pkg::OP_S_WR: begin
          qpos_q <= qpos_q + QIW'(1);
        end
        bjas_pkg::OP_Q_DEC: begin
          count_q <= count_q - CNT_W'(1);
        end
        bjas_pkg::OP_FIN: begin
          valid_q[hit_idx_q] <= 1'b0;
          run_q[hit_idx_q]   <= 1'b0;
          if (running_q != '0) running_q <= running_q - CNT_W'(1);
        end
        bjas_pkg::OP_POP_RUN: begin
          valid_q[pop_slot] <= 1'b1;
          run_q[pop_slot]   <= 1'b1;
          head_q            <= qwrap(head_w + (QIW+1)'(1));
          count_q           <= count_q - CNT_W'(1);
          running_q         <= running_inc;
          if (running_inc > rpeak_q) rpeak_q <= running_inc;
        end
        bjas_pkg::OP_POP_CLR: begin
          valid_q[pop_slot] <= 1'b0;
          run_q[pop_slot]   <= 1'b0;
          head_q            <= qwrap(head_w + (QIW+1)'(1));
          count_q           <= count_q - CNT_W'(1);
        end
        default: begin
          hit_q <= hit_q;
        end
      endcase
    end
  end

  // terminal state of a finished job
  always_comb begin
    if (outcome_q == bjas_pkg::OUTCOME_SUCCEEDED) begin
      fin_state = bjas_pkg::EV_SUCCEEDED;
    end else if (outcome_q == bjas_pkg::OUTCOME_CANCELLED) begin
      fin_state = bjas_pkg::EV_CANCELLED;
    end else begin
      fin_state = bjas_pkg::EV_FAILED;
    end
  end

  // output register: load when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = out_free && ((cmd_i.op == bjas_pkg::OP_EMIT_EV_IN) ||
                                 (cmd_i.op == bjas_pkg::OP_EMIT_EV_POP) ||
                                 (cmd_i.op == bjas_pkg::OP_EMIT_REPLY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cmd_i.op == bjas_pkg::OP_EMIT_REPLY) begin
        item_kind_o      <= 1'b1;
        event_session_o  <= '0;
        event_job_o      <= '0;
        event_state_o    <= '0;
        reply_code_o     <= cmd_i.reply;
        queued_now_o     <= count_q;
        running_now_o    <= running_q;
        queued_peak_o    <= qpeak_q;
        running_peak_o   <= rpeak_q;
        accepting_flag_o <= accepting_q;
        last_item_o      <= 1'b1;
      end else begin
        item_kind_o      <= 1'b0;
        if (cmd_i.op == bjas_pkg::OP_EMIT_EV_POP) begin
          event_session_o <= fifo_rd_q[FE_W-1:FE_W-bjas_pkg::ID_W];
          event_job_o     <= fifo_rd_q[TIW+bjas_pkg::ID_W-1:TIW];
        end else begin
          event_session_o <= sid_q;
          event_job_o     <= jid_q;
        end
        event_state_o    <= cmd_i.ev_state;
        reply_code_o     <= '0;
        queued_now_o     <= '0;
        running_now_o    <= '0;
        queued_peak_o    <= '0;
        running_peak_o   <= '0;
        accepting_flag_o <= 1'b0;
        last_item_o      <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // status towards the controller
  always_comb begin
    sts_o.out_free   = out_free;
    sts_o.func       = func_q;
    sts_o.key_zero   = (sid_q == '0) || (jid_q == '0);
    sts_o.accepting  = accepting_q;
    sts_o.match_now  = t_match;
    sts_o.tidx_last  = (tidx_q == T_LAST);
    sts_o.hit        = hit_q;
    sts_o.hit_run    = run_q[hit_idx_q];
    sts_o.free_ok    = free_ok_q;
    sts_o.run_lt_max = running_q < max_run_q;
    sts_o.q_full     = count_q >= cap;
    sts_o.q_nonempty = count_q != '0;
    sts_o.qmatch_now = q_match;
    sts_o.more1      = more1;
    sts_o.more2      = more2;
    sts_o.promo_ok   = accepting_q && (count_q != '0) && (running_q < max_run_q);
    sts_o.fin_state  = fin_state;
  end

endmodule

// ===== hdl/bjas_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjas_ctrl: scheduler controller
// Sequences table search, queue search and shift, promotion, shutdown drain
// and result emission, one datapath operation per cycle, holding an emission while the output register is not free.
// ----------------------------------------------------------------------------
module bjas_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output bjas_pkg::cmd_t cmd_o,
  input  bjas_pkg::sts_t sts_i
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_DECODE   = 18'h00002,
    S_T_RD     = 18'h00004,
    S_T_CMP    = 18'h00008,
    S_T_DONE   = 18'h00010,
    S_Q_RD     = 18'h00020,
    S_Q_CMP    = 18'h00040,
    S_S_RD     = 18'h00080,
    S_S_WR     = 18'h00100,
    S_Q_DEC    = 18'h00200,
    S_EV_IN    = 18'h00400,
    S_PROMO    = 18'h00800,
    S_POP_RD   = 18'h01000,
    S_POP_UPD  = 18'h02000,
    S_EV_POP   = 18'h04000,
    S_SHUT_CHK = 18'h08000,
    S_REPLY    = 18'h10000,
    S_SPARE    = 18'h20000
  } state_e;

  state_e              state_q, state_d;
  bjas_pkg::reply_e    rcode_q, rcode_d;
  bjas_pkg::ev_state_e evs_q, evs_d;
  logic                is_finish;

  assign in_stall_o = (state_q != S_IDLE);
  assign is_finish  = (sts_i.func == bjas_pkg::FUNC_FINISH);

  always_comb begin
    state_d         = state_q;
    rcode_d         = rcode_q;
    evs_d           = evs_q;
    cmd_o.op        = bjas_pkg::OP_NONE;
    cmd_o.ev_state  = evs_q;
    cmd_o.reply     = rcode_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bjas_pkg::OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      // early submit checks, shutdown entry
      S_DECODE: begin
        unique case (sts_i.func)
          bjas_pkg::FUNC_SUBMIT: begin
            if (sts_i.key_zero) begin
              rcode_d = bjas_pkg::RC_INVALID_ID;
              state_d = S_REPLY;
            end else if (!sts_i.accepting) begin
              rcode_d = bjas_pkg::RC_SHUTTING;
              state_d = S_REPLY;
            end else begin
              state_d = S_T_RD;
            end
          end
          bjas_pkg::FUNC_CANCEL, bjas_pkg::FUNC_FINISH: begin
            state_d = S_T_RD;
          end
          bjas_pkg::FUNC_SHUTDOWN: begin
            cmd_o.op = bjas_pkg::OP_SHUT;
            state_d  = S_SHUT_CHK;
          end
        endcase
      end
      // walk the key table
      S_T_RD: begin
        cmd_o.op = bjas_pkg::OP_T_RD;
        state_d  = S_T_CMP;
      end
      S_T_CMP: begin
        cmd_o.op = bjas_pkg::OP_T_CMP;
        state_d  = (sts_i.match_now || sts_i.tidx_last) ? S_T_DONE : S_T_RD;
      end
      // act on the search result
      S_T_DONE: begin
        unique case (sts_i.func)
          bjas_pkg::FUNC_SUBMIT: begin
            priority if (sts_i.hit) begin
              rcode_d = bjas_pkg::RC_DUPLICATE;
              state_d = S_REPLY;
            end else if (!sts_i.free_ok) begin
              rcode_d = bjas_pkg::RC_QUEUE_FULL;
              state_d = S_REPLY;
            end else if (sts_i.run_lt_max) begin
              cmd_o.op = bjas_pkg::OP_START;
              evs_d    = bjas_pkg::EV_RUNNING;
              rcode_d  = bjas_pkg::RC_ACCEPTED;
              state_d  = S_EV_IN;
            end else if (sts_i.q_full) begin
              rcode_d = bjas_pkg::RC_QUEUE_FULL;
              state_d = S_REPLY;
            end else begin
              cmd_o.op = bjas_pkg::OP_ENQ;
              evs_d    = bjas_pkg::EV_QUEUED;
              rcode_d  = bjas_pkg::RC_ACCEPTED;
              state_d  = S_EV_IN;
            end
          end
          bjas_pkg::FUNC_CANCEL: begin
            priority if (!sts_i.hit) begin
              rcode_d = bjas_pkg::RC_NOT_FOUND;
              state_d = S_REPLY;
            end else if (sts_i.hit_run) begin
              rcode_d = bjas_pkg::RC_FOUND;
              state_d = S_REPLY;
            end else begin
              cmd_o.op = bjas_pkg::OP_CLR_HIT;
              evs_d    = bjas_pkg::EV_CANCELLED;
              rcode_d  = bjas_pkg::RC_FOUND;
              state_d  = S_Q_RD;
            end
          end
          bjas_pkg::FUNC_FINISH: begin
            if (!sts_i.hit || !sts_i.hit_run) begin
              rcode_d = bjas_pkg::RC_NOT_FOUND;
              state_d = S_REPLY;
            end else begin
              cmd_o.op = bjas_pkg::OP_FIN;
              evs_d    = sts_i.fin_state;
              rcode_d  = bjas_pkg::RC_DONE;
              state_d  = S_EV_IN;
            end
          end
          bjas_pkg::FUNC_SHUTDOWN: begin
            rcode_d = bjas_pkg::RC_DONE;
            state_d = S_REPLY;
          end
        endcase
      end
      // find the cancelled job in the queue
      S_Q_RD: begin
        cmd_o.op = bjas_pkg::OP_Q_RD;
        state_d  = S_Q_CMP;
      end
      S_Q_CMP: begin
        cmd_o.op = bjas_pkg::OP_Q_CMP;
        priority if (sts_i.qmatch_now) begin
          state_d = sts_i.more1 ? S_S_RD : S_Q_DEC;
        end else if (sts_i.more1) begin
          state_d = S_Q_RD;
        end else begin
          state_d = S_EV_IN;
        end
      end
      // close the gap behind the removed job
      S_S_RD: begin
        cmd_o.op = bjas_pkg::OP_S_RD;
        state_d  = S_S_WR;
      end
      S_S_WR: begin
        cmd_o.op = bjas_pkg::OP_S_WR;
        state_d  = sts_i.more2 ? S_S_RD : S_Q_DEC;
      end
      S_Q_DEC: begin
        cmd_o.op = bjas_pkg::OP_Q_DEC;
        state_d  = S_EV_IN;
      end
      // event for the commanded job
      S_EV_IN: begin
        cmd_o.op = bjas_pkg::OP_EMIT_EV_IN;
        if (sts_i.out_free) begin
          state_d = is_finish ? S_PROMO : S_REPLY;
        end
      end
      S_PROMO: begin
        state_d = sts_i.promo_ok ? S_POP_RD : S_REPLY;
      end
      // pop the queue head
      S_POP_RD: begin
        cmd_o.op = bjas_pkg::OP_POP_RD;
        state_d  = S_POP_UPD;
      end
      S_POP_UPD: begin
        cmd_o.op = is_finish ? bjas_pkg::OP_POP_RUN : bjas_pkg::OP_POP_CLR;
        evs_d    = is_finish ? bjas_pkg::EV_RUNNING : bjas_pkg::EV_CANCELLED;
        state_d  = S_EV_POP;
      end
      S_EV_POP: begin
        cmd_o.op = bjas_pkg::OP_EMIT_EV_POP;
        if (sts_i.out_free) begin
          state_d = is_finish ? S_REPLY : S_SHUT_CHK;
        end
      end
      // drain the queue on shutdown
      S_SHUT_CHK: begin
        if (sts_i.q_nonempty) begin
          state_d = S_POP_RD;
        end else begin
          rcode_d = bjas_pkg::RC_DONE;
          state_d = S_REPLY;
        end
      end
      S_REPLY: begin
        cmd_o.op = bjas_pkg::OP_EMIT_REPLY;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rcode_q <= bjas_pkg::RC_ACCEPTED;
      evs_q   <= bjas_pkg::EV_QUEUED;
    end else begin
      state_q <= state_d;
      rcode_q <= rcode_d;
      evs_q   <= evs_d;
    end
  end

endmodule

// ===== hdl/bounded_job_admission_scheduler.sv =====
`timescale 1ns / 1ps
// Commands are taken one at a time. A stalled output holds a command while a ready
// result item waits. The key search reads the table memory and compares one entry
// at a time, a cancel walks the queue and shifts each waiting job behind the removed
// one forward, and shutdown pops each waiting job and emits its cancelled event.
// Reset is asynchronous and active low; it clears flags and counters at once.
// ----------------------------------------------------------------------------
// bounded_job_admission_scheduler: top level
// Admits, queues, cancels and finishes jobs under a running-count limit and
// reports lifecycle events followed by one reply per command.
// ----------------------------------------------------------------------------
module bounded_job_admission_scheduler #(
  parameter int unsigned QUEUE_DEPTH = bjas_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TABLE_DEPTH = bjas_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bjas_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bjas_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [bjas_pkg::ID_W-1:0]      session_id_i,
  input  logic [bjas_pkg::ID_W-1:0]      job_id_i,
  input  logic [1:0]                     job_outcome_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           item_kind_o,
  output logic [bjas_pkg::ID_W-1:0]      event_session_o,
  output logic [bjas_pkg::ID_W-1:0]      event_job_o,
  output logic [2:0]                     event_state_o,
  output logic [2:0]                     reply_code_o,
  output logic [bjas_pkg::CNT_W-1:0]     queued_now_o,
  output logic [bjas_pkg::CNT_W-1:0]     running_now_o,
  output logic [bjas_pkg::CNT_W-1:0]     queued_peak_o,
  output logic [bjas_pkg::CNT_W-1:0]     running_peak_o,
  output logic                           accepting_flag_o,
  output logic                           last_item_o
);

  bjas_pkg::cmd_t cmd;
  bjas_pkg::sts_t sts;

  bjas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bjas_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cfg_ready_o      (cfg_ready_o),
    .func_i           (func_i),
    .session_id_i     (session_id_i),
    .job_id_i         (job_id_i),
    .job_outcome_i    (job_outcome_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .event_session_o  (event_session_o),
    .event_job_o      (event_job_o),
    .event_state_o    (event_state_o),
    .reply_code_o     (reply_code_o),
    .queued_now_o     (queued_now_o),
    .running_now_o    (running_now_o),
    .queued_peak_o    (queued_peak_o),
    .running_peak_o   (running_peak_o),
    .accepting_flag_o (accepting_flag_o),
    .last_item_o      (last_item_o)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_job_admission_scheduler
// Drives submit, cancel, finish and shutdown commands, first from a directed
// table and then at random over several limit settings and idling modes. A
// scoreboard model of the job table and wait queue predicts every event and
// reply, and each output item is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bjas_pkg::*;

  localparam int unsigned TBL_DEPTH  = 32;
  localparam int unsigned Q_DEPTH    = 16;
  localparam int unsigned WDOG_LIMIT = 6000;
  localparam int unsigned DIR_EARLY  = 19;
  localparam int unsigned DIR_ROWS   = 22;
  localparam int unsigned N_PHASES   = 7;

  typedef struct packed {
    logic        kind;
    logic [31:0] sess;
    logic [31:0] job;
    logic [2:0]  state;
    logic [2:0]  code;
    logic [4:0]  q_now;
    logic [4:0]  r_now;
    logic [4:0]  q_peak;
    logic [4:0]  r_peak;
    logic        acc;
    logic        last;
  } job_result_t;

  typedef struct {
    func_e       f;
    logic [31:0] s;
    logic [31:0] j;
    logic [1:0]  o;
    bit          chk;
    reply_e      code;
  } cmd_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CNT_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [1:0] func_i, job_outcome_i;
  logic [31:0] session_id_i, job_id_i;
  logic out_valid_o, out_stall_i;
  logic item_kind_o, accepting_flag_o, last_item_o;
  logic [31:0] event_session_o, event_job_o;
  logic [2:0] event_state_o, reply_code_o;
  logic [4:0] queued_now_o, running_now_o, queued_peak_o, running_peak_o;

  bounded_job_admission_scheduler uut (.*);

  // scheduler model state
  logic [63:0] job_keys [TBL_DEPTH];
  bit          job_live [TBL_DEPTH];
  bit          job_runs [TBL_DEPTH];
  logic [63:0] wait_line [$];
  int unsigned run_count, run_peak, wait_peak, lim_running, lim_waiting;
  bit          admitting;
  job_result_t expected_items [$];

  int unsigned mismatches, row_errors, idle_cycles, send_idle_pct, recv_stall_pct;

  cmd_row_t cmd_rows [DIR_ROWS] = '{
    '{FUNC_SUBMIT,   32'd0,        32'd0,        2'd0, 1'b1, RC_INVALID_ID},
    '{FUNC_SUBMIT,   32'd0,        32'd5,        2'd0, 1'b1, RC_INVALID_ID},
    '{FUNC_SUBMIT,   32'd5,        32'd0,        2'd0, 1'b1, RC_INVALID_ID},
    '{FUNC_CANCEL,   32'd0,        32'd0,        2'd0, 1'b1, RC_NOT_FOUND},
    '{FUNC_FINISH,   32'd1,        32'd1,        2'd3, 1'b1, RC_NOT_FOUND},
    '{FUNC_SUBMIT,   32'hFFFFFFFF, 32'hFFFFFFFF, 2'd3, 1'b1, RC_ACCEPTED},
    '{FUNC_SUBMIT,   32'hFFFFFFFF, 32'hFFFFFFFF, 2'd0, 1'b1, RC_DUPLICATE},
    '{FUNC_SUBMIT,   32'd1,        32'd1,        2'd0, 1'b1, RC_ACCEPTED},
    '{FUNC_SUBMIT,   32'd1,        32'd2,        2'd0, 1'b1, RC_ACCEPTED},
    '{FUNC_SUBMIT,   32'd1,        32'd3,        2'd0, 1'b1, RC_ACCEPTED},
    '{FUNC_SUBMIT,   32'd2,        32'd1,        2'd0, 1'b1, RC_ACCEPTED},
    '{FUNC_SUBMIT,   32'd2,        32'd2,        2'd0, 1'b0, RC_ACCEPTED},
    '{FUNC_CANCEL,   32'd1,        32'd1,        2'd0, 1'b1, RC_FOUND},
    '{FUNC_CANCEL,   32'd2,        32'd1,        2'd0, 1'b1, RC_FOUND},
    '{FUNC_FINISH,   32'd2,        32'd2,        2'd0, 1'b1, RC_NOT_FOUND},
    '{FUNC_FINISH,   32'hFFFFFFFF, 32'hFFFFFFFF, 2'd0, 1'b1, RC_DONE},
    '{FUNC_FINISH,   32'd1,        32'd1,        2'd1, 1'b1, RC_DONE},
    '{FUNC_FINISH,   32'd1,        32'd2,        2'd2, 1'b0, RC_DONE},
    '{FUNC_FINISH,   32'd1,        32'd3,        2'd3, 1'b0, RC_DONE},
    // shutdown rows, walked at the very end
    '{FUNC_SHUTDOWN, 32'hFFFFFFFF, 32'h0,        2'd3, 1'b1, RC_DONE},
    '{FUNC_SHUTDOWN, 32'd0,        32'd0,        2'd0, 1'b1, RC_DONE},
    '{FUNC_SUBMIT,   32'd3,        32'd3,        2'd0, 1'b1, RC_SHUTTING}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int find_job(logic [63:0] key);
    for (int i = 0; i < TBL_DEPTH; i++)
      if (job_live[i] && job_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic void add_event(logic [63:0] key, ev_state_e st);
    job_result_t r;
    r = '0;
    r.sess  = key[63:32];
    r.job   = key[31:0];
    r.state = st;
    expected_items = {expected_items, r};
  endfunction

  function automatic void add_reply(reply_e code);
    job_result_t r;
    r = '0;
    r.kind   = 1'b1;
    r.code   = code;
    r.q_now  = 5'(wait_line.size());
    r.r_now  = 5'(run_count);
    r.q_peak = 5'(wait_peak);
    r.r_peak = 5'(run_peak);
    r.acc    = admitting;
    r.last   = 1'b1;
    expected_items = {expected_items, r};
  endfunction

  function automatic void start_job(int slot, logic [63:0] key);
    job_keys[slot] = key;
    job_live[slot] = 1'b1;
    job_runs[slot] = 1'b1;
    run_count++;
    if (run_count > run_peak) run_peak = run_count;
  endfunction

  // predict the events and reply of one accepted command
  function automatic void predict_command(func_e f, logic [31:0] s, logic [31:0] j,
                                          logic [1:0] o);
    logic [63:0] key, nk;
    int t, slot;
    int unsigned cap;
    key = {s, j};
    t = find_job(key);
    cap = (lim_waiting < Q_DEPTH) ? lim_waiting : Q_DEPTH;
    case (f)
      FUNC_SUBMIT: begin
        slot = -1;
        for (int i = TBL_DEPTH - 1; i >= 0; i--)
          if (!job_live[i]) slot = i;
        if (s == 0 || j == 0) add_reply(RC_INVALID_ID);
        else if (!admitting) add_reply(RC_SHUTTING);
        else if (t >= 0) add_reply(RC_DUPLICATE);
        else if (slot < 0) add_reply(RC_QUEUE_FULL);
        else if (run_count < lim_running) begin
          start_job(slot, key);
          add_event(key, EV_RUNNING);
          add_reply(RC_ACCEPTED);
        end else if (wait_line.size() >= cap) add_reply(RC_QUEUE_FULL);
        else begin
          job_keys[slot] = key;
          job_live[slot] = 1'b1;
          job_runs[slot] = 1'b0;
          wait_line = {wait_line, key};
          if (wait_line.size() > wait_peak) wait_peak = wait_line.size();
          add_event(key, EV_QUEUED);
          add_reply(RC_ACCEPTED);
        end
      end
      FUNC_CANCEL: begin
        if (t < 0) add_reply(RC_NOT_FOUND);
        else if (job_runs[t]) add_reply(RC_FOUND);
        else begin
          for (int i = 0; i < wait_line.size(); i++)
            if (wait_line[i] == key) begin
              wait_line.delete(i);
              break;
            end
          job_live[t] = 1'b0;
          add_event(key, EV_CANCELLED);
          add_reply(RC_FOUND);
        end
      end
      FUNC_FINISH: begin
        if (t < 0 || !job_runs[t]) add_reply(RC_NOT_FOUND);
        else begin
          job_live[t] = 1'b0;
          job_runs[t] = 1'b0;
          if (run_count > 0) run_count--;
          add_event(key, o == OUTCOME_SUCCEEDED ? EV_SUCCEEDED :
                         (o == OUTCOME_CANCELLED ? EV_CANCELLED : EV_FAILED));
          if (admitting && wait_line.size() > 0 && run_count < lim_running) begin
            nk = wait_line[0];
            wait_line.delete(0);
            slot = find_job(nk);
            if (slot >= 0) job_runs[slot] = 1'b1;
            run_count++;
            if (run_count > run_peak) run_peak = run_count;
            add_event(nk, EV_RUNNING);
          end
          add_reply(RC_DONE);
        end
      end
      default: begin
        admitting = 1'b0;
        while (wait_line.size() > 0) begin
          nk = wait_line[0];
          wait_line.delete(0);
          slot = find_job(nk);
          if (slot >= 0) job_live[slot] = 1'b0;
          add_event(nk, EV_CANCELLED);
        end
        add_reply(RC_DONE);
      end
    endcase
  endfunction

  // present one command, hold it until taken, then update the model
  task automatic send_command(func_e f, logic [31:0] s, logic [31:0] j, logic [1:0] o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    session_id_i  <= s;
    job_id_i      <= j;
    job_outcome_i <= o;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(f, s, j, o);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MAX_RUNNING) lim_running = 32'(val);
    else lim_waiting = 32'(val);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_items.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // pick a key: mostly live jobs or a small pool, sometimes zero or wide
  task automatic pick_key(output logic [31:0] s, output logic [31:0] j);
    int live [$];
    int unsigned r;
    for (int i = 0; i < TBL_DEPTH; i++)
      if (job_live[i]) live = {live, i};
    r = $urandom_range(99);
    if (live.size() > 0 && r < 55) begin
      {s, j} = job_keys[live[$urandom_range(live.size() - 1)]];
    end else if (r < 62) begin
      s = $urandom_range(1) ? 32'd0 : $urandom();
      j = $urandom_range(1) ? 32'd0 : $urandom();
    end else if (r < 72) begin
      s = $urandom();
      j = $urandom();
    end else begin
      s = $urandom_range(1, 4);
      j = $urandom_range(1, 40);
    end
  endtask

  // receiver side: random stall, check each taken item against the model
  always @(posedge clk_i or negedge rst_ni) begin
    job_result_t got, want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mismatches = 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        got = {item_kind_o, event_session_o, event_job_o, event_state_o, reply_code_o,
               queued_now_o, running_now_o, queued_peak_o, running_peak_o,
               accepting_flag_o, last_item_o};
        if (expected_items.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", got);
        end else begin
          want = expected_items[0];
          expected_items.delete(0);
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kind %0d/%0d key %h_%h/%h_%h state %0d/%0d code %0d/%0d",
                       got.kind, want.kind, got.sess, got.job, want.sess, want.job,
                       got.state, want.state, got.code, want.code,
                       " counts q%0d r%0d qp%0d rp%0d acc%0d last%0d",
                       got.q_now, got.r_now, got.q_peak, got.r_peak, got.acc, got.last,
                       " / q%0d r%0d qp%0d rp%0d acc%0d last%0d",
                       want.q_now, want.r_now, want.q_peak, want.r_peak, want.acc,
                       want.last);
          end
        end
      end
    end
  end

  // watchdog: count cycles in which no handshake completes
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned run_lims [N_PHASES] = '{1, 16, 0, 31, 2, 3, 4};
    int unsigned wait_lims [N_PHASES] = '{0, 16, 5, 31, 3, 1, 16};
    logic [31:0] s, j;
    int unsigned r;
    func_e f;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_MAX_RUNNING;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    func_i        <= FUNC_SUBMIT;
    session_id_i  <= '0;
    job_id_i      <= '0;
    job_outcome_i <= '0;
    row_errors     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    lim_running    = 32'(MAX_RUN_RST);
    lim_waiting    = 32'(QCAP_RST);
    admitting      = 1'b1;
    run_count      = 0;
    run_peak       = 0;
    wait_peak      = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      job_live[i] = 1'b0;
      job_runs[i] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands under reset limits
    for (int i = 0; i < DIR_EARLY; i++) begin
      send_command(cmd_rows[i].f, cmd_rows[i].s, cmd_rows[i].j, cmd_rows[i].o);
      if (cmd_rows[i].chk && expected_items[$].code !== cmd_rows[i].code) begin
        row_errors++;
        if (row_errors <= 10)
          $display("row %0d: model code %0d, table %0d", i, expected_items[$].code,
                   cmd_rows[i].code);
      end
    end

    // random phases, each under new limits and an idling mode
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_limit(CFG_MAX_RUNNING, 5'(run_lims[p]));
      write_limit(CFG_QUEUE_CAPACITY, 5'(wait_lims[p]));
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < 45; n++) begin
        pick_key(s, j);
        r = $urandom_range(99);
        if (p == N_PHASES - 1 && r < 3) f = FUNC_SHUTDOWN;
        else if (r < 50) f = FUNC_SUBMIT;
        else if (r < 65) f = FUNC_CANCEL;
        else f = FUNC_FINISH;
        send_command(f, s, j, 2'($urandom_range(3)));
      end
    end

    // shutdown and what follows it
    for (int i = DIR_EARLY; i < DIR_ROWS; i++) begin
      send_command(cmd_rows[i].f, cmd_rows[i].s, cmd_rows[i].j, cmd_rows[i].o);
      if (cmd_rows[i].chk && expected_items[$].code !== cmd_rows[i].code) begin
        row_errors++;
        if (row_errors <= 10)
          $display("row %0d: model code %0d, table %0d", i, expected_items[$].code,
                   cmd_rows[i].code);
      end
    end

    wait_drained();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && row_errors == 0 && expected_items.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
